[hw/rtl/page_frame_allocator_unit_assert.svh]
// assertion macros used by the page frame allocator port checker
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page frame allocator check failed");

// next-cycle implication, disabled while reset is asserted
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page frame allocator check failed");

`endif

[hw/rtl/pfa_pkg.sv]
// shared types and constants of the page frame allocator
package pfa_pkg;

    // command codes
    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_ALLOC     = 3'd1,
        OP_RETAIN    = 3'd2,
        OP_RELEASE   = 3'd3,
        OP_SHARE     = 3'd4,
        OP_UNSHARE   = 3'd5,
        OP_MARK_COW  = 3'd6,
        OP_CLEAR_COW = 3'd7
    } cmd_op_t;

    // page flag bit positions
    localparam int FLAG_FREE   = 0;
    localparam int FLAG_ALLOC  = 1;
    localparam int FLAG_RSVD   = 2;
    localparam int FLAG_SHARED = 3;
    localparam int FLAG_COW    = 4;
    localparam int FLAG_DIRTY  = 5;

    // fixed field widths of the stream payload
    localparam int FLAGS_W    = 6;
    localparam int PAGE_IDX_W = 12;
    localparam int CNT_PORT_W = 16;
    localparam int PAGE_CNT_W = 13;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_UNLINK,
        ST_LINK,
        ST_PUSH,
        ST_DONE
    } seq_state_t;

    // free list actions decided by the entry update
    typedef struct packed {
        logic do_unlink;
        logic do_push;
        logic on_list;
    } list_ctrl_t;

endpackage

[hw/rtl/page_frame_allocator_unit.sv]
// page frame allocator: page entry memory, free list link memories and command sequencer
// the sequencer steps through idle, read and exec, then unlink, link and push as needed, and done
// loads the result into the output register; s_tready is high only in idle, so a new command is
// taken only once the last result is in the output register; link memories take one write a cycle
// reset: synchronous active low; afterwards a clearing pass zeroes all NUM_PAGES entries of the
// page entry memory one entry a cycle with s_tready low; config writes are taken meanwhile
module page_frame_allocator_unit
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES   = 4096,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config: page_count
    input  logic                  cfg_wr_en,
    input  logic [PAGE_CNT_W-1:0] cfg_wr_data,
    // command beat
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // page_index[11:0], init_flags[17:12], init_refcount[33:18], init_sharecount[49:34]
    input  logic [55:0]           s_tdata,
    // op[2:0]
    input  logic [2:0]            s_tuser,
    // result beat
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_page[11:0], result_flags[17:12], result_refcount[33:18],
    // result_sharecount[49:34], free_count[62:50]
    output logic [63:0]           m_tdata,
    // done_ok[0]
    output logic [0:0]            m_tuser
);

    // page address, link (one extra code for the null link) and entry widths
    localparam int PW = $clog2(NUM_PAGES);
    localparam int LW = $clog2(NUM_PAGES + 1);
    localparam int CW = COUNT_WIDTH;
    localparam int EW = 1 + FLAGS_W + 2 * CW;

    localparam logic [LW-1:0]   NIL_LINK  = LW'(NUM_PAGES);
    localparam logic [PW-1:0]   LAST_PAGE = PW'(NUM_PAGES - 1);
    localparam logic [31:0]     NUM_PAGES_W = 32'(NUM_PAGES);

    // entry layout: {on_list, flags, refcount, sharecount}
    localparam int SH_LO = 0;
    localparam int RC_LO = CW;
    localparam int FL_LO = 2 * CW;
    localparam int OL_BIT = 2 * CW + FLAGS_W;

    // ---------------------------------------------------------------
    // memories
    // ---------------------------------------------------------------
    logic [EW-1:0] ent_mem [NUM_PAGES];
    logic [LW-1:0] nxt_mem [NUM_PAGES];
    logic [LW-1:0] prv_mem [NUM_PAGES];

    logic          ent_we;
    logic [PW-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata;
    logic          nxt_we;
    logic [PW-1:0] nxt_waddr;
    logic [LW-1:0] nxt_wdata;
    logic          prv_we;
    logic [PW-1:0] prv_waddr;
    logic [LW-1:0] prv_wdata;
    logic          mem_re;

    logic [EW-1:0] ent_rd_reg;
    logic [LW-1:0] nxt_rd_reg;
    logic [LW-1:0] prv_rd_reg;

    // ---------------------------------------------------------------
    // control and datapath registers
    // ---------------------------------------------------------------
    seq_state_t state_reg, state_next;

    logic [PAGE_CNT_W-1:0] page_count_reg;
    logic [LW-1:0]         head_reg, head_next;
    logic [LW-1:0]         free_reg, free_next;
    logic [PW-1:0]         clr_idx_reg;

    // command latched at accept
    cmd_op_t               op_reg;
    logic [PW-1:0]         page_reg;
    logic [PAGE_IDX_W-1:0] res_page_reg;
    logic                  ok_reg;
    logic [FLAGS_W-1:0]    init_flags_reg;
    logic [CNT_PORT_W-1:0] init_ref_reg;
    logic [CNT_PORT_W-1:0] init_share_reg;

    // entry state after the command
    logic [FLAGS_W-1:0]    res_flags_reg;
    logic [CW-1:0]         res_ref_reg;
    logic [CW-1:0]         res_share_reg;
    logic                  push_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           out_data_reg;
    logic                  out_ok_reg;
    logic                  out_load;

    // ---------------------------------------------------------------
    // entry update unit
    // ---------------------------------------------------------------
    logic [FLAGS_W-1:0] upd_flags;
    logic [CW-1:0]      upd_ref;
    logic [CW-1:0]      upd_share;
    list_ctrl_t         upd_ctrl;

    pfa_entry_update #(
        .COUNT_WIDTH(CW)
    ) u_update (
        .op         (op_reg),
        .flags_in   (ent_rd_reg[FL_LO +: FLAGS_W]),
        .ref_in     (ent_rd_reg[RC_LO +: CW]),
        .share_in   (ent_rd_reg[SH_LO +: CW]),
        .on_list_in (ent_rd_reg[OL_BIT]),
        .init_flags (init_flags_reg),
        .init_ref   (init_ref_reg),
        .init_share (init_share_reg),
        .flags_out  (upd_flags),
        .ref_out    (upd_ref),
        .share_out  (upd_share),
        .ctrl       (upd_ctrl)
    );

    // ---------------------------------------------------------------
    // input decode at accept
    // ---------------------------------------------------------------
    logic                  in_accept;
    cmd_op_t               in_op;
    logic [PAGE_IDX_W-1:0] in_page;
    logic                  in_page_ok;
    logic                  head_valid;

    assign in_accept  = s_tvalid && s_tready;
    assign in_op      = cmd_op_t'(s_tuser[2:0]);
    assign in_page    = s_tdata[11:0];
    assign head_valid = head_reg < NIL_LINK;
    // in range of both the programmed count and the memory depth
    assign in_page_ok = ({1'b0, in_page} < page_count_reg) && (32'(in_page) < NUM_PAGES_W);

    // unlink neighbours, valid when the link is not null
    logic pv_valid;
    logic nx_valid;
    assign pv_valid = prv_rd_reg < NIL_LINK;
    assign nx_valid = nxt_rd_reg < NIL_LINK;

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == LAST_PAGE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!ok_reg) begin
                    state_next = ST_DONE;
                end else if (upd_ctrl.do_unlink) begin
                    state_next = ST_UNLINK;
                end else if (upd_ctrl.do_push || op_reg == OP_LOAD) begin
                    state_next = ST_LINK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_UNLINK: begin
                // own links are always rewritten after an unlink
                state_next = ST_LINK;
            end
            ST_LINK: begin
                state_next = push_reg ? ST_PUSH : ST_DONE;
            end
            ST_PUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs and memory port control
    // ---------------------------------------------------------------
    always_comb begin
        s_tready  = 1'b0;
        mem_re    = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = page_reg;
        ent_wdata = {upd_ctrl.on_list, upd_flags, upd_ref, upd_share};
        nxt_we    = 1'b0;
        nxt_waddr = page_reg;
        nxt_wdata = NIL_LINK;
        prv_we    = 1'b0;
        prv_waddr = page_reg;
        prv_wdata = NIL_LINK;
        head_next = head_reg;
        free_next = free_reg;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                // only the on-list bit matters, the rest is zeroed with it
                ent_we    = 1'b1;
                ent_waddr = clr_idx_reg;
                ent_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_EXEC: begin
                ent_we = ok_reg;
            end
            ST_UNLINK: begin
                // bridge prev to next, or move the head past this page
                nxt_we    = pv_valid;
                nxt_waddr = prv_rd_reg[PW-1:0];
                nxt_wdata = nxt_rd_reg;
                prv_we    = nx_valid;
                prv_waddr = nxt_rd_reg[PW-1:0];
                prv_wdata = pv_valid ? prv_rd_reg : NIL_LINK;
                if (!pv_valid) begin
                    head_next = nx_valid ? nxt_rd_reg : NIL_LINK;
                end
                if (free_reg != '0) begin
                    free_next = free_reg - LW'(1);
                end
            end
            ST_LINK: begin
                // own links: null, or chained in front of the current head
                nxt_we    = 1'b1;
                nxt_wdata = push_reg ? head_reg : NIL_LINK;
                prv_we    = 1'b1;
            end
            ST_PUSH: begin
                prv_we    = head_valid;
                prv_waddr = head_reg[PW-1:0];
                prv_wdata = LW'(page_reg);
                head_next = LW'(page_reg);
                free_next = free_reg + LW'(1);
            end
            ST_DONE: begin
                out_load = !out_valid_reg || m_tready;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // memories: one write and one registered read per cycle each
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (mem_re) begin
            ent_rd_reg <= ent_mem[page_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (mem_re) begin
            nxt_rd_reg <= nxt_mem[page_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (prv_we) begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        if (mem_re) begin
            prv_rd_reg <= prv_mem[page_reg];
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            page_count_reg <= PAGE_CNT_W'(4096);
            head_reg       <= NIL_LINK;
            free_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + PW'(1);
            end
            if (cfg_wr_en) begin
                page_count_reg <= cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg         <= in_op;
            init_flags_reg <= s_tdata[17:12];
            init_ref_reg   <= s_tdata[33:18];
            init_share_reg <= s_tdata[49:34];
            if (in_op == OP_ALLOC) begin
                // alloc acts on the head, empty list reports page zero
                ok_reg       <= head_valid;
                page_reg     <= head_reg[PW-1:0];
                res_page_reg <= head_valid ? PAGE_IDX_W'(head_reg) : '0;
            end else begin
                ok_reg       <= in_page_ok;
                page_reg     <= PW'(in_page);
                res_page_reg <= in_page;
            end
        end
        if (state_reg == ST_EXEC) begin
            res_flags_reg <= upd_flags;
            res_ref_reg   <= upd_ref;
            res_share_reg <= upd_share;
            push_reg      <= upd_ctrl.do_push;
        end
        if (out_load) begin
            out_ok_reg          <= ok_reg;
            out_data_reg[11:0]  <= res_page_reg;
            out_data_reg[17:12] <= ok_reg ? res_flags_reg : '0;
            out_data_reg[33:18] <= ok_reg ? CNT_PORT_W'(res_ref_reg) : '0;
            out_data_reg[49:34] <= ok_reg ? CNT_PORT_W'(res_share_reg) : '0;
            out_data_reg[62:50] <= PAGE_CNT_W'(free_reg);
            out_data_reg[63]    <= 1'b0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ok_reg;

endmodule

[hw/rtl/pfa_entry_update.sv]
// flag and count update of one page entry for each command
module pfa_entry_update
    import pfa_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  cmd_op_t                op,
    input  logic [FLAGS_W-1:0]     flags_in,
    input  logic [COUNT_WIDTH-1:0] ref_in,
    input  logic [COUNT_WIDTH-1:0] share_in,
    input  logic                   on_list_in,
    input  logic [FLAGS_W-1:0]     init_flags,
    input  logic [CNT_PORT_W-1:0]  init_ref,
    input  logic [CNT_PORT_W-1:0]  init_share,
    output logic [FLAGS_W-1:0]     flags_out,
    output logic [COUNT_WIDTH-1:0] ref_out,
    output logic [COUNT_WIDTH-1:0] share_out,
    output list_ctrl_t             ctrl
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;

    always_comb begin
        logic [FLAGS_W-1:0]     f;
        logic [COUNT_WIDTH-1:0] r;
        logic [COUNT_WIDTH-1:0] s;
        logic                   unl;
        logic                   psh;
        f   = flags_in;
        r   = ref_in;
        s   = share_in;
        unl = 1'b0;
        psh = 1'b0;
        unique case (op)
            OP_LOAD: begin
                unl = on_list_in;
                f   = init_flags;
                r   = COUNT_WIDTH'(init_ref);
                s   = COUNT_WIDTH'(init_share);
                psh = init_flags[FLAG_FREE];
            end
            OP_ALLOC: begin
                unl            = 1'b1;
                f[FLAG_FREE]   = 1'b0;
                f[FLAG_RSVD]   = 1'b0;
                f[FLAG_SHARED] = 1'b0;
                f[FLAG_COW]    = 1'b0;
                f[FLAG_ALLOC]  = 1'b1;
                r              = CNT_ONE;
                s              = CNT_ONE;
            end
            OP_RETAIN: begin
                if (f[FLAG_FREE]) begin
                    unl           = on_list_in;
                    f[FLAG_FREE]  = 1'b0;
                    f[FLAG_RSVD]  = 1'b0;
                    f[FLAG_ALLOC] = 1'b1;
                end
                if (r != CNT_MAX) begin
                    r = r + CNT_ONE;
                end
                if (r == CNT_ONE) begin
                    s = CNT_ONE;
                end
            end
            OP_RELEASE: begin
                if (r != CNT_ZERO) begin
                    r = r - CNT_ONE;
                    if (r == CNT_ZERO && !f[FLAG_RSVD]) begin
                        f[FLAG_ALLOC]  = 1'b0;
                        f[FLAG_SHARED] = 1'b0;
                        f[FLAG_COW]    = 1'b0;
                        f[FLAG_FREE]   = 1'b1;
                        s              = CNT_ZERO;
                        psh            = !f[FLAG_DIRTY] && !on_list_in;
                    end
                end
            end
            OP_SHARE: begin
                if (!f[FLAG_SHARED]) begin
                    f[FLAG_SHARED] = 1'b1;
                    if (s == CNT_ZERO) begin
                        s = CNT_ONE;
                    end
                end
                if (s != CNT_MAX) begin
                    s = s + CNT_ONE;
                end
            end
            OP_UNSHARE: begin
                if (f[FLAG_SHARED]) begin
                    if (s != CNT_ZERO) begin
                        s = s - CNT_ONE;
                    end
                    if (s <= CNT_ONE) begin
                        f[FLAG_SHARED] = 1'b0;
                    end
                end
            end
            OP_MARK_COW: begin
                f[FLAG_COW] = 1'b1;
            end
            OP_CLEAR_COW: begin
                f[FLAG_COW] = 1'b0;
            end
        endcase
        flags_out      = f;
        ref_out        = r;
        share_out      = s;
        ctrl.do_unlink = unl;
        ctrl.do_push   = psh;
        ctrl.on_list   = psh ? 1'b1 : (unl ? 1'b0 : on_list_in);
    end

endmodule

[hw/rtl/pfa_checker.sv]
// port level checks of the page frame allocator and their binding
`include "page_frame_allocator_unit_assert.svh"

module pfa_checker #(
    parameter int NUM_PAGES = 4096
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result beat holds its payload
    `PFA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one command at a time: busy right after an accepted beat
    `PFA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // failed command reports no page state
    `PFA_ASSERT_NOW(a_fail_zero_state, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[49:12] == 38'd0)

    // free list never holds more pages than exist
    `PFA_ASSERT_NOW(a_free_bound, aclk, aresetn, m_tvalid, 32'(m_tdata[62:50]) <= 32'(NUM_PAGES))

endmodule

bind page_frame_allocator_unit pfa_checker #(
    .NUM_PAGES(NUM_PAGES)
) u_pfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/sv/pfa_frame_checker.sv]
// checker for the page frame allocator: predicts each command's report and compares the result beats
`timescale 1ns / 1ps

module pfa_frame_checker
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [PAGE_CNT_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [55:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [63:0]           m_tdata,
    input  logic [0:0]            m_tuser,
    output int                    pending,
    output int                    mismatches
);

    localparam int unsigned NIL_LINK = NUM_PAGES;

    typedef struct packed {
        logic                  done_ok;
        logic [PAGE_IDX_W-1:0] page;
        logic [FLAGS_W-1:0]    flags;
        logic [CNT_PORT_W-1:0] refcount;
        logic [CNT_PORT_W-1:0] sharecount;
        logic [PAGE_CNT_W-1:0] free_cnt;
    } frame_report_t;

    // shadow of the page table and the free list
    logic [FLAGS_W-1:0]    pg_flags [NUM_PAGES];
    bit                    listed   [NUM_PAGES];
    logic [CNT_PORT_W-1:0] refs     [NUM_PAGES];
    logic [CNT_PORT_W-1:0] shares   [NUM_PAGES];
    int unsigned           nxt      [NUM_PAGES];
    int unsigned           prv      [NUM_PAGES];
    int unsigned           head;
    int unsigned           nfree;
    int unsigned           page_limit;

    frame_report_t frame_reports_due[$];
    int            err_total = 0;

    function automatic void unlink_frame(int unsigned p);
        int unsigned pv;
        int unsigned nx;
        pv = prv[p];
        nx = nxt[p];
        if (pv < NUM_PAGES) nxt[pv] = nx;
        else head = (nx < NUM_PAGES) ? nx : NIL_LINK;
        if (nx < NUM_PAGES) prv[nx] = (pv < NUM_PAGES) ? pv : NIL_LINK;
        nxt[p]    = NIL_LINK;
        prv[p]    = NIL_LINK;
        listed[p] = 1'b0;
        if (nfree > 0) nfree--;
    endfunction

    function automatic void push_frame(int unsigned p);
        prv[p] = NIL_LINK;
        nxt[p] = head;
        if (head < NUM_PAGES) prv[head] = p;
        head      = p;
        listed[p] = 1'b1;
        nfree++;
    endfunction

    function automatic frame_report_t predict_frame_update(
        cmd_op_t op, logic [PAGE_IDX_W-1:0] idx, logic [FLAGS_W-1:0] ld_flags,
        logic [CNT_PORT_W-1:0] ld_refs, logic [CNT_PORT_W-1:0] ld_shares);
        frame_report_t r;
        int unsigned   p;
        int unsigned   lim;
        logic [FLAGS_W-1:0] f;
        bit            ok;
        p   = 32'(idx);
        lim = (page_limit < NUM_PAGES) ? page_limit : NUM_PAGES;
        ok  = 1'b1;
        if (op == OP_ALLOC) begin
            if (head >= NUM_PAGES) begin
                ok = 1'b0;
                p  = 0;
            end else begin
                // the head is taken even if it now lies above the page count
                p = head;
                unlink_frame(p);
                f = pg_flags[p];
                f[FLAG_FREE]   = 1'b0;
                f[FLAG_RSVD]   = 1'b0;
                f[FLAG_SHARED] = 1'b0;
                f[FLAG_COW]    = 1'b0;
                f[FLAG_ALLOC]  = 1'b1;
                pg_flags[p] = f;
                refs[p]     = CNT_PORT_W'(1);
                shares[p]   = CNT_PORT_W'(1);
            end
        end else if (p >= lim) begin
            ok = 1'b0;
        end else begin
            f = pg_flags[p];
            case (op)
                OP_LOAD: begin
                    if (listed[p]) unlink_frame(p);
                    nxt[p]    = NIL_LINK;
                    prv[p]    = NIL_LINK;
                    f         = ld_flags;
                    refs[p]   = ld_refs;
                    shares[p] = ld_shares;
                    if (f[FLAG_FREE]) push_frame(p);
                end
                OP_RETAIN: begin
                    if (f[FLAG_FREE]) begin
                        // a dirty page freed by release is flagged free but not listed
                        if (listed[p]) unlink_frame(p);
                        f[FLAG_FREE]  = 1'b0;
                        f[FLAG_RSVD]  = 1'b0;
                        f[FLAG_ALLOC] = 1'b1;
                    end
                    if (refs[p] != '1) refs[p] = refs[p] + 1'b1;
                    if (refs[p] == 1) shares[p] = CNT_PORT_W'(1);
                end
                OP_RELEASE: begin
                    if (refs[p] != 0) begin
                        refs[p] = refs[p] - 1'b1;
                        if (refs[p] == 0 && !f[FLAG_RSVD]) begin
                            f[FLAG_ALLOC]  = 1'b0;
                            f[FLAG_SHARED] = 1'b0;
                            f[FLAG_COW]    = 1'b0;
                            f[FLAG_FREE]   = 1'b1;
                            shares[p]      = '0;
                            if (!f[FLAG_DIRTY] && !listed[p]) push_frame(p);
                        end
                    end
                end
                OP_SHARE: begin
                    if (!f[FLAG_SHARED]) begin
                        f[FLAG_SHARED] = 1'b1;
                        if (shares[p] == 0) shares[p] = CNT_PORT_W'(1);
                    end
                    if (shares[p] != '1) shares[p] = shares[p] + 1'b1;
                end
                OP_UNSHARE: begin
                    if (f[FLAG_SHARED]) begin
                        if (shares[p] != 0) shares[p] = shares[p] - 1'b1;
                        if (shares[p] <= 1) f[FLAG_SHARED] = 1'b0;
                    end
                end
                OP_MARK_COW: f[FLAG_COW] = 1'b1;
                default:     f[FLAG_COW] = 1'b0;
            endcase
            pg_flags[p] = f;
        end
        r.done_ok    = ok;
        r.page       = p[PAGE_IDX_W-1:0];
        r.flags      = ok ? pg_flags[p] : '0;
        r.refcount   = ok ? refs[p] : '0;
        r.sharecount = ok ? shares[p] : '0;
        r.free_cnt   = nfree[PAGE_CNT_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            err_total++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        frame_report_t want;
        frame_report_t got;
        if (!aresetn) begin
            page_limit = 4096;
            head       = NIL_LINK;
            nfree      = 0;
            for (int i = 0; i < NUM_PAGES; i++) begin
                listed[i]   = 1'b0;
                pg_flags[i] = '0;
                refs[i]     = '0;
                shares[i]   = '0;
                nxt[i]      = 0;
                prv[i]      = 0;
            end
            frame_reports_due.delete();
        end else begin
            if (cfg_wr_en) page_limit = 32'(cfg_wr_data);
            if (m_tvalid && m_tready) begin
                got.done_ok    = m_tuser[0];
                got.page       = m_tdata[11:0];
                got.flags      = m_tdata[17:12];
                got.refcount   = m_tdata[33:18];
                got.sharecount = m_tdata[49:34];
                got.free_cnt   = m_tdata[62:50];
                if (frame_reports_due.size() == 0) begin
                    err_total++;
                    $display("%0t: result beat with none due, expected nothing actual 0x%0h",
                             $time, got);
                end else begin
                    want = frame_reports_due.pop_front();
                    compare_field("done_ok", want.done_ok, got.done_ok);
                    compare_field("result_page", want.page, got.page);
                    compare_field("result_flags", want.flags, got.flags);
                    compare_field("result_refcount", want.refcount, got.refcount);
                    compare_field("result_sharecount", want.sharecount, got.sharecount);
                    compare_field("free_count", want.free_cnt, got.free_cnt);
                end
            end
            if (s_tvalid && s_tready)
                frame_reports_due.push_back(predict_frame_update(cmd_op_t'(s_tuser),
                    s_tdata[11:0], s_tdata[17:12], s_tdata[33:18], s_tdata[49:34]));
        end
        pending    <= frame_reports_due.size();
        mismatches <= err_total;
    end

endmodule

[tb/sv/tb_top.sv]
// top of the page frame allocator testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import pfa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;   // clearing pass plus a slow run, many times over
    localparam int DRAIN_TAIL  = 12;       // extra idle time after the last report has come back
    localparam int HOT_PAGES   = 48;       // working set that most commands hit

    localparam logic [FLAGS_W-1:0] F_FREE  = 6'(1) << FLAG_FREE;
    localparam logic [FLAGS_W-1:0] F_ALLOC = 6'(1) << FLAG_ALLOC;
    localparam logic [FLAGS_W-1:0] F_RSVD  = 6'(1) << FLAG_RSVD;
    localparam logic [FLAGS_W-1:0] F_DIRTY = 6'(1) << FLAG_DIRTY;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [PAGE_CNT_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [55:0]           s_tdata     = '0;
    logic [2:0]            s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [63:0]           m_tdata;
    logic [0:0]            m_tuser;

    int pending;
    int mismatches;

    // stimulus knobs
    int          src_idle_pct   = 0;      // only touched by the stimulus thread
    int          sink_stall_pct = 0;      // changed with nonblocking writes, read at the edge
    logic        rx_hold        = 1'b0;   // long receiver hold-off
    int unsigned page_limit     = 4096;   // page_count as last written
    bit          loaded [4096];           // pages whose entry has been written
    int          sent_total     = 0;
    int          cycles         = 0;

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    page_frame_allocator_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    pfa_frame_checker u_frame_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    // result side: random stalls, forced low during a hold-off
    always @(posedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one command beat; random idle cycles before it, then hold until accepted
    task automatic send_cmd(input cmd_op_t op, input logic [PAGE_IDX_W-1:0] idx,
                            input logic [FLAGS_W-1:0] fl, input logic [CNT_PORT_W-1:0] rc,
                            input logic [CNT_PORT_W-1:0] sc);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        // page_index[11:0], init_flags[17:12], init_refcount[33:18], init_sharecount[49:34]
        s_tdata  <= {6'd0, sc, rc, fl, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // a load past the page count is ignored and writes nothing
        if (op == OP_LOAD && idx < page_limit) loaded[idx] = 1'b1;
        sent_total++;
    endtask

    // stop offering and wait until every report has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // page_count is only changed with the allocator idle
    task automatic set_page_count(input int unsigned value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[PAGE_CNT_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        page_limit = value;
    endtask

    // mostly small counts so release reaches zero, some full range and near saturation
    function automatic logic [CNT_PORT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return CNT_PORT_W'($urandom_range(0, 3));
        if (roll < 8) return CNT_PORT_W'($urandom_range(0, 65535));
        return (roll == 8) ? 16'hFFFF : 16'hFFFE;
    endfunction

    // random command mix over a small working set, so pages cycle through
    // load, alloc, retain, share and release and the free list grows and shrinks
    task automatic random_cmds(input int n_items, input bit pause_midway);
        cmd_op_t                op;
        logic [PAGE_IDX_W-1:0] idx;
        logic [FLAGS_W-1:0]    fl;
        int unsigned           roll;
        int unsigned           hot;
        for (int k = 0; k < n_items; k++) begin
            if (pause_midway && k == n_items / 2) drain();
            roll = $urandom_range(0, 99);
            if (roll < 22)      op = OP_LOAD;
            else if (roll < 36) op = OP_ALLOC;
            else if (roll < 50) op = OP_RETAIN;
            else if (roll < 68) op = OP_RELEASE;
            else if (roll < 76) op = OP_SHARE;
            else if (roll < 84) op = OP_UNSHARE;
            else if (roll < 92) op = OP_MARK_COW;
            else                op = OP_CLEAR_COW;
            hot  = (page_limit < HOT_PAGES) ? page_limit : HOT_PAGES;
            roll = $urandom_range(0, 99);
            if (roll < 8 && page_limit < 4096)
                idx = PAGE_IDX_W'($urandom_range(page_limit, 4095));
            else if (roll < 16)
                idx = PAGE_IDX_W'($urandom_range(0, page_limit - 1));
            else
                idx = PAGE_IDX_W'($urandom_range(0, hot - 1));
            // never touch an entry that was not written yet
            if (op != OP_LOAD && op != OP_ALLOC && idx < page_limit && !loaded[idx])
                op = OP_LOAD;
            fl = FLAGS_W'($urandom_range(0, 63));
            if ($urandom_range(0, 3) != 0) fl[FLAG_RSVD] = 1'b0;
            if ($urandom_range(0, 3) != 0) fl[FLAG_DIRTY] = 1'b0;
            send_cmd(op, idx, fl, pick_count(), pick_count());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // written during the clearing pass; the first command waits for s_tready
        set_page_count(4096);

        // directed: extremes, every command and the corner cases
        send_cmd(OP_LOAD, 12'd0, F_FREE, 16'h0000, 16'h0000);
        send_cmd(OP_LOAD, 12'd4095, 6'h3F, 16'hFFFF, 16'hFFFF);
        send_cmd(OP_LOAD, 12'd1, F_ALLOC, 16'hFFFF, 16'hFFFF);
        send_cmd(OP_RETAIN, 12'd1, '0, '0, '0);              // refcount saturates
        send_cmd(OP_SHARE, 12'd1, '0, '0, '0);               // sharecount saturates
        send_cmd(OP_UNSHARE, 12'd1, '0, '0, '0);
        send_cmd(OP_ALLOC, 12'd0, '0, '0, '0);               // pops page 4095
        send_cmd(OP_LOAD, 12'd2, F_FREE, 16'd1, 16'd0);
        send_cmd(OP_RELEASE, 12'd2, '0, '0, '0);             // already listed, no second push
        send_cmd(OP_LOAD, 12'd3, F_ALLOC | F_DIRTY, 16'd1, 16'd2);
        send_cmd(OP_RELEASE, 12'd3, '0, '0, '0);             // freed but dirty, stays off list
        send_cmd(OP_RETAIN, 12'd3, '0, '0, '0);              // free flag without list entry
        send_cmd(OP_LOAD, 12'd4, F_ALLOC | F_RSVD, 16'd1, 16'd0);
        send_cmd(OP_RELEASE, 12'd4, '0, '0, '0);             // reserved page is kept
        send_cmd(OP_LOAD, 12'd5, F_ALLOC, 16'd0, 16'd0);
        send_cmd(OP_RELEASE, 12'd5, '0, '0, '0);             // refcount already zero
        send_cmd(OP_SHARE, 12'd5, '0, '0, '0);               // zero sharecount starts at one
        send_cmd(OP_UNSHARE, 12'd5, '0, '0, '0);             // drops to one, shared clears
        send_cmd(OP_UNSHARE, 12'd5, '0, '0, '0);             // not shared, no effect
        send_cmd(OP_MARK_COW, 12'd5, '0, '0, '0);
        send_cmd(OP_CLEAR_COW, 12'd5, '0, '0, '0);
        send_cmd(OP_LOAD, 12'd0, F_ALLOC, 16'd1, 16'd1);     // load unlinks a listed page
        send_cmd(OP_ALLOC, 12'd0, '0, '0, '0);
        send_cmd(OP_ALLOC, 12'd0, '0, '0, '0);               // list empty
        send_cmd(OP_LOAD, 12'd6, F_FREE, 16'd0, 16'd0);
        set_page_count(2);
        send_cmd(OP_RETAIN, 12'd4095, '0, '0, '0);           // index past the page count
        send_cmd(OP_ALLOC, 12'd0, '0, '0, '0);               // head lies past the page count

        // random phases, each with its own page count and pacing
        set_page_count(64);
        random_cmds(540, 1'b0);

        set_page_count(4096);
        src_idle_pct = 67;
        random_cmds(480, 1'b0);

        set_page_count(1);
        src_idle_pct = 0;
        sink_stall_pct <= 67;
        random_cmds(300, 1'b0);

        set_page_count(32);
        src_idle_pct = 11;
        sink_stall_pct <= 11;
        // long hold-off on the result side so the allocator backs up into s_tready
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        random_cmds(450, 1'b1);

        drain();
        $display("ran %0d commands over page counts 4096, 2, 64, 1 and 32", sent_total);
        $display("with free pacing, sender gaps, result stalls, both, a long hold and a pause");
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_entry_update.sv
hw/rtl/page_frame_allocator_unit.sv
hw/rtl/pfa_checker.sv
tb/sv/pfa_frame_checker.sv
tb/sv/tb_top.sv
